// ----- rtl/ccl_pkg.sv -----
// Shared types and constants for the connected-component labeling block.
package ccl_pkg;

    localparam int RC_W    = 7;
    localparam int LABEL_W = 11;
    localparam int IDX_W   = 12;
    localparam int FUNC_W  = 2;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 32;

    localparam logic [LABEL_W-1:0] LABEL_MAX = '1;
    localparam logic [RC_W-1:0]    DIM_RESET = 7'd64;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Neighbor k: which direction it moves in, one bit per k.
    // k: 0 W, 1 E, 2 NW, 3 N, 4 NE, 5 SW, 6 S, 7 SE
    localparam logic [7:0] NB_UP    = 8'b0001_1100;
    localparam logic [7:0] NB_DOWN  = 8'b1110_0000;
    localparam logic [7:0] NB_LEFT  = 8'b0010_0101;
    localparam logic [7:0] NB_RIGHT = 8'b1001_0010;

    typedef struct packed {
        logic [RC_W-1:0] rows;
        logic [RC_W-1:0] cols;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ADV,
        S_POP,
        S_POPW,
        S_NRD,
        S_NCHK,
        S_DONE
    } t_state;

endpackage

// ----- rtl/ccl_regs.sv -----
// APB register file holding the image geometry.
module ccl_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ccl_pkg::CFG_AW-1:0]  paddr,
    input  logic [ccl_pkg::CFG_DW-1:0]  pwdata,
    output logic [ccl_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output ccl_pkg::t_cfg               o_cfg
);
    import ccl_pkg::*;

    logic [RC_W-1:0] r_rows;
    logic [RC_W-1:0] r_cols;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= DIM_RESET;
            r_cols <= DIM_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_ROWS) begin
                r_rows <= pwdata[RC_W-1:0];
            end else begin
                r_cols <= pwdata[RC_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_COLS) begin
            prdata = {{(CFG_DW-RC_W){1'b0}}, r_cols};
        end else begin
            prdata = {{(CFG_DW-RC_W){1'b0}}, r_rows};
        end
    end

    assign o_cfg.rows = r_rows;
    assign o_cfg.cols = r_cols;

endmodule

// ----- rtl/connected_component_labeling.sv -----
// Connected-component labeling (8-connected) over a pixel/label memory and a flood queue.
// Pixel writes and label reads may arrive back to back while busy is low; a read
// answers with a one-cycle strobe in the cycle after it is accepted, and write items give
// no answer. A run holds busy high while it first clears the label slice of the cell
// memory, then scans the active image with a read, a check and an advance step per cell;
// each foreground pixel adds a queue pop and its wait step, plus a skip step per out-of-image
// neighbor and a read step and a check-and-write step per in-image neighbor, and each
// component adds a final pop that finds its queue empty, all set by the single read port
// of the cell memory. The count appears as a one-cycle strobe as the run ends. After
// reset the block is busy while the label memory is cleared; configuration writes are
// taken at any time. The receiver cannot stall: every result must be captured in its
// strobe cycle.
module connected_component_labeling #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ccl_pkg::CFG_AW-1:0]   paddr,
    input  logic [ccl_pkg::CFG_DW-1:0]   pwdata,
    output logic [ccl_pkg::CFG_DW-1:0]   prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic [ccl_pkg::FUNC_W-1:0]   i_func,
    input  logic [ccl_pkg::IDX_W-1:0]    i_pixel_index,
    input  logic                         i_pixel_value,
    output logic                         o_result_valid,
    output logic [ccl_pkg::LABEL_W-1:0]  o_result_value,
    output logic                         o_is_count
);
    import ccl_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int QW    = $clog2(CELLS + 1);
    localparam int QE_W  = AW + 2 * RC_W;
    localparam logic [RC_W-1:0] ROW_CAP   = (MAX_ROWS > 127) ? 7'd127 : RC_W'(MAX_ROWS);
    localparam logic [RC_W-1:0] COL_CAP   = (MAX_COLS > 127) ? 7'd127 : RC_W'(MAX_COLS);
    localparam logic [AW-1:0]   LAST_CELL = AW'(CELLS - 1);

    t_cfg cfg;

    // cell memory: {pixel, label}
    logic [LABEL_W:0]   cell_mem [CELLS];
    logic [LABEL_W:0]   r_rdata;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               we_pix;
    logic               we_lab;
    logic               wr_pix;
    logic [LABEL_W-1:0] wr_lab;

    logic [QE_W-1:0]    q_mem [CELLS];
    logic [QE_W-1:0]    r_qdata;
    logic               q_we;
    logic [AW-1:0]      q_waddr;
    logic [QE_W-1:0]    q_wdata;

    t_state             r_state, n_state;
    logic [RC_W-1:0]    r_rows, n_rows;
    logic [RC_W-1:0]    r_cols, n_cols;
    logic [LABEL_W-1:0] r_count, n_count;
    logic               r_run, n_run;
    logic [AW-1:0]      r_clr, n_clr;
    logic [RC_W-1:0]    r_srow, n_srow;
    logic [RC_W-1:0]    r_scol, n_scol;
    logic [AW-1:0]      r_sflat, n_sflat;
    logic [QW-1:0]      r_head, n_head;
    logic [QW-1:0]      r_tail, n_tail;
    logic [RC_W-1:0]    r_prow, n_prow;
    logic [RC_W-1:0]    r_pcol, n_pcol;
    logic [AW-1:0]      r_pflat, n_pflat;
    logic [2:0]         r_k, n_k;
    logic [RC_W-1:0]    r_nrow, n_nrow;
    logic [RC_W-1:0]    r_ncol, n_ncol;
    logic [AW-1:0]      r_np, n_np;
    logic               r_out_valid, n_out_valid;
    logic               r_out_count, n_out_count;
    logic               r_rd_ok, n_rd_ok;

    logic [RC_W-1:0]    act_rows;
    logic [RC_W-1:0]    act_cols;
    logic [2*RC_W-1:0]  act_size;
    logic               idx_ok;
    logic               accept;
    logic [AW-1:0]      cols_aw;
    logic               nb_up, nb_down, nb_left, nb_right;
    logic               nb_ok;
    logic [RC_W-1:0]    nb_row;
    logic [RC_W-1:0]    nb_col;
    logic [AW-1:0]      nb_flat;
    logic               hit;
    logic [LABEL_W-1:0] count_inc;

    ccl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign act_rows = (cfg.rows > ROW_CAP) ? ROW_CAP : cfg.rows;
    assign act_cols = (cfg.cols > COL_CAP) ? COL_CAP : cfg.cols;
    assign act_size = (2*RC_W)'(act_rows) * (2*RC_W)'(act_cols);
    assign idx_ok   = (2*RC_W)'(i_pixel_index) < act_size;
    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;

    // neighbor position of the popped pixel
    assign cols_aw  = AW'(r_cols);
    assign nb_up    = NB_UP[r_k];
    assign nb_down  = NB_DOWN[r_k];
    assign nb_left  = NB_LEFT[r_k];
    assign nb_right = NB_RIGHT[r_k];
    assign nb_ok    = !(nb_up && r_prow == '0) && !(nb_down && r_prow == r_rows - RC_W'(1))
                   && !(nb_left && r_pcol == '0)
                   && !(nb_right && r_pcol == r_cols - RC_W'(1));

    always_comb begin
        nb_row = r_prow;
        nb_col = r_pcol;
        nb_flat = r_pflat;
        if (nb_up) begin
            nb_row  = r_prow - RC_W'(1);
            nb_flat = nb_flat - cols_aw;
        end else if (nb_down) begin
            nb_row  = r_prow + RC_W'(1);
            nb_flat = nb_flat + cols_aw;
        end
        if (nb_left) begin
            nb_col  = r_pcol - RC_W'(1);
            nb_flat = nb_flat - AW'(1);
        end else if (nb_right) begin
            nb_col  = r_pcol + RC_W'(1);
            nb_flat = nb_flat + AW'(1);
        end
    end

    assign hit       = r_rdata[LABEL_W] && (r_rdata[LABEL_W-1:0] == '0);
    assign count_inc = (r_count == LABEL_MAX) ? r_count : r_count + LABEL_W'(1);

    always_comb begin
        n_state     = r_state;
        n_rows      = r_rows;
        n_cols      = r_cols;
        n_count     = r_count;
        n_run       = r_run;
        n_clr       = r_clr;
        n_srow      = r_srow;
        n_scol      = r_scol;
        n_sflat     = r_sflat;
        n_head      = r_head;
        n_tail      = r_tail;
        n_prow      = r_prow;
        n_pcol      = r_pcol;
        n_pflat     = r_pflat;
        n_k         = r_k;
        n_nrow      = r_nrow;
        n_ncol      = r_ncol;
        n_np        = r_np;
        n_out_valid = 1'b0;
        n_out_count = r_out_count;
        n_rd_ok     = r_rd_ok;
        rd_addr     = AW'(i_pixel_index);
        wr_addr     = AW'(i_pixel_index);
        we_pix      = 1'b0;
        we_lab      = 1'b0;
        wr_pix      = i_pixel_value;
        wr_lab      = '0;
        q_we        = 1'b0;
        q_waddr     = r_tail[AW-1:0];
        q_wdata     = {r_np, r_nrow, r_ncol};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_func)
                        FUNC_WRITE: begin
                            we_pix = idx_ok;
                        end
                        FUNC_RUN: begin
                            n_rows  = act_rows;
                            n_cols  = act_cols;
                            n_count = '0;
                            n_run   = 1'b1;
                            n_clr   = '0;
                            n_srow  = '0;
                            n_scol  = '0;
                            n_sflat = '0;
                            n_state = S_CLEAR;
                        end
                        FUNC_READ: begin
                            n_out_valid = 1'b1;
                            n_out_count = 1'b0;
                            n_rd_ok     = idx_ok;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR: begin
                we_lab  = 1'b1;
                wr_addr = r_clr;
                wr_lab  = '0;
                if (r_clr == LAST_CELL) begin
                    if (!r_run) begin
                        n_state = S_IDLE;
                    end else if (r_rows == '0 || r_cols == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_SCAN_RD: begin
                rd_addr = r_sflat;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (hit) begin
                    // new component: label the seed and queue it
                    n_count = count_inc;
                    we_lab  = 1'b1;
                    wr_addr = r_sflat;
                    wr_lab  = count_inc;
                    q_we    = 1'b1;
                    q_waddr = '0;
                    q_wdata = {r_sflat, r_srow, r_scol};
                    n_head  = '0;
                    n_tail  = QW'(1);
                    n_state = S_POP;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_ADV: begin
                if (r_srow == r_rows - RC_W'(1) && r_scol == r_cols - RC_W'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_sflat = r_sflat + AW'(1);
                    if (r_scol == r_cols - RC_W'(1)) begin
                        n_scol = '0;
                        n_srow = r_srow + RC_W'(1);
                    end else begin
                        n_scol = r_scol + RC_W'(1);
                    end
                    n_state = S_SCAN_RD;
                end
            end
            S_POP: begin
                if (r_head == r_tail) begin
                    n_state = S_ADV;
                end else begin
                    n_head  = r_head + QW'(1);
                    n_state = S_POPW;
                end
            end
            S_POPW: begin
                n_pflat = r_qdata[QE_W-1 -: AW];
                n_prow  = r_qdata[2*RC_W-1 -: RC_W];
                n_pcol  = r_qdata[RC_W-1:0];
                n_k     = '0;
                n_state = S_NRD;
            end
            S_NRD: begin
                rd_addr = nb_flat;
                n_np    = nb_flat;
                n_nrow  = nb_row;
                n_ncol  = nb_col;
                if (nb_ok) begin
                    n_state = S_NCHK;
                end else if (r_k == 3'd7) begin
                    n_state = S_POP;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_NCHK: begin
                if (hit) begin
                    we_lab  = 1'b1;
                    wr_addr = r_np;
                    wr_lab  = r_count;
                    q_we    = 1'b1;
                    n_tail  = r_tail + QW'(1);
                end
                if (r_k == 3'd7) begin
                    n_state = S_POP;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = S_NRD;
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_out_count = 1'b1;
                n_run       = 1'b0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rows      <= DIM_RESET;
            r_cols      <= DIM_RESET;
            r_count     <= '0;
            r_run       <= 1'b0;
            r_clr       <= '0;
            r_srow      <= '0;
            r_scol      <= '0;
            r_sflat     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_out_count <= 1'b0;
            r_rd_ok     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rows      <= n_rows;
            r_cols      <= n_cols;
            r_count     <= n_count;
            r_run       <= n_run;
            r_clr       <= n_clr;
            r_srow      <= n_srow;
            r_scol      <= n_scol;
            r_sflat     <= n_sflat;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            r_out_count <= n_out_count;
            r_rd_ok     <= n_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prow  <= n_prow;
        r_pcol  <= n_pcol;
        r_pflat <= n_pflat;
        r_nrow  <= n_nrow;
        r_ncol  <= n_ncol;
        r_np    <= n_np;
    end

    always_ff @(posedge i_clk) begin
        if (we_pix) begin
            cell_mem[wr_addr][LABEL_W] <= wr_pix;
        end
        if (we_lab) begin
            cell_mem[wr_addr][LABEL_W-1:0] <= wr_lab;
        end
        r_rdata <= cell_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        r_qdata <= q_mem[r_head[AW-1:0]];
    end

    assign o_result_valid = r_out_valid;
    assign o_is_count     = r_out_count;
    assign o_result_value = r_out_count ? r_count
                          : (r_rd_ok ? r_rdata[LABEL_W-1:0] : '0);

`ifndef ASSERT_OFF
    a_read_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FUNC_READ) |=> (o_result_valid && !o_is_count))
        else $error("read transaction not answered in the next cycle");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FUNC_RUN) |=> busy)
        else $error("run transaction did not raise busy");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_state) != S_IDLE && r_state != S_IDLE)
        |-> (r_count >= $past(r_count)))
        else $error("component count decreased during a run");
`endif

endmodule
